@@ hdl/addressable_led_serial_driver_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the addressable LED serial driver
// Shared property wrappers, sampled on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_SERIAL_DRIVER_UNIT_ASSERT_SVH
`define ADDRESSABLE_LED_SERIAL_DRIVER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ALSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ALSD_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ hdl/alsd_pkg.sv @@
// ----------------------------------------------------------------------------
// alsd_pkg
// Types, codes and defaults shared by the LED serial driver modules.
// ----------------------------------------------------------------------------
package alsd_pkg;

  localparam int MaxLedsDefault = 256;

  localparam int ReqTypeW  = 2;
  localparam int LedIndexW = 8;
  localparam int PixelW    = 24;
  localparam int LedCountW = 9;
  localparam int ShortW    = 10;
  localparam int LongW     = 16;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;
  localparam int BitPtrW   = 5;
  localparam int PhaseW    = 3;

  // request codes
  localparam logic [ReqTypeW-1:0] REQ_WRITE = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_START = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_TICK  = 2'd2;
  localparam logic [ReqTypeW-1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_LED_COUNT   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_ZERO_HIGH   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_ZERO_LOW    = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_ONE_HIGH    = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_ONE_LOW     = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_RESET_LOW   = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_LATCH_LOW   = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_SETTLE      = 3'd7;

  // register defaults
  localparam logic [LedCountW-1:0] LED_COUNT_RST  = 9'd256;
  localparam logic [ShortW-1:0]    ZERO_HIGH_RST  = 10'd8;
  localparam logic [ShortW-1:0]    ZERO_LOW_RST   = 10'd17;
  localparam logic [ShortW-1:0]    ONE_HIGH_RST   = 10'd16;
  localparam logic [ShortW-1:0]    ONE_LOW_RST    = 10'd9;
  localparam logic [LongW-1:0]     RESET_LOW_RST  = 16'd2000;
  localparam logic [LongW-1:0]     LATCH_LOW_RST  = 16'd1200;
  localparam logic [ShortW-1:0]    SETTLE_RST     = 10'd20;

  // frame phase codes
  localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
  localparam logic [PhaseW-1:0] PH_RESET  = 3'd1;
  localparam logic [PhaseW-1:0] PH_HIGH   = 3'd2;
  localparam logic [PhaseW-1:0] PH_LOW    = 3'd3;
  localparam logic [PhaseW-1:0] PH_LATCH  = 3'd4;
  localparam logic [PhaseW-1:0] PH_SETTLE = 3'd5;

  localparam logic [BitPtrW-1:0] LAST_BIT = 5'(PixelW - 1);

  typedef struct packed {
    logic [ShortW-1:0] zero_high;
    logic [ShortW-1:0] zero_low;
    logic [ShortW-1:0] one_high;
    logic [ShortW-1:0] one_low;
    logic [LongW-1:0]  reset_low;
    logic [LongW-1:0]  latch_low;
    logic [ShortW-1:0] settle;
  } timing_t;

  typedef struct packed {
    logic start;
    logic tick;
  } seq_cmd_t;

  typedef struct packed {
    logic busy_now;
    logic busy_next;
    logic level;
    logic done;
  } seq_stat_t;

  // A zero duration counts as one tick.
  function automatic logic [LongW-1:0] at_least_one(logic [LongW-1:0] v);
    return (v == '0) ? LongW'(1) : v;
  endfunction

endpackage

@@ hdl/alsd_pixel_mem.sv @@
// ----------------------------------------------------------------------------
// alsd_pixel_mem
// Colour store with registered read; entries never written read as zero.
// ----------------------------------------------------------------------------
module alsd_pixel_mem #(
  parameter int Depth = alsd_pkg::MaxLedsDefault,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [alsd_pkg::PixelW-1:0] wr_data_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [alsd_pkg::PixelW-1:0] rd_data_o
);

  logic [alsd_pkg::PixelW-1:0] mem_q [Depth];
  logic [alsd_pkg::PixelW-1:0] rd_data_q;
  logic [Depth-1:0]            valid_q;
  logic                        rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // mask entries not yet written since reset
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

@@ hdl/alsd_frame_seq.sv @@
// ----------------------------------------------------------------------------
// alsd_frame_seq
// Frame phase sequencer: phase, LED and bit pointers and tick counter.
// ----------------------------------------------------------------------------
module alsd_frame_seq #(
  parameter int MaxLeds = alsd_pkg::MaxLedsDefault,
  parameter int PtrW    = (MaxLeds > 1) ? $clog2(MaxLeds) : 1,
  parameter int CntW    = ($clog2(MaxLeds + 1) > alsd_pkg::LedCountW) ?
                          $clog2(MaxLeds + 1) : alsd_pkg::LedCountW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alsd_pkg::seq_cmd_t          cmd_i,
  input  alsd_pkg::timing_t           timing_i,
  input  logic [CntW-1:0]             eff_count_i,
  input  logic [alsd_pkg::PixelW-1:0] pix_word_i,
  output logic [PtrW-1:0]             rd_addr_o,
  output alsd_pkg::seq_stat_t         stat_o
);

  logic [alsd_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [PtrW-1:0]              led_ptr_q, led_ptr_d;
  logic [alsd_pkg::BitPtrW-1:0] bit_ptr_q, bit_ptr_d;
  logic [alsd_pkg::LongW-1:0]   tick_cnt_q, tick_cnt_d;
  logic [alsd_pkg::LongW-1:0]   tick_inc;
  logic [alsd_pkg::LongW-1:0]   phase_len;
  logic                         cur_bit;
  logic                         done;

  assign cur_bit  = pix_word_i[alsd_pkg::LAST_BIT - bit_ptr_q];
  assign tick_inc = tick_cnt_q + alsd_pkg::LongW'(1);

  always_comb begin
    unique case (phase_q)
      alsd_pkg::PH_RESET:  phase_len = alsd_pkg::at_least_one(timing_i.reset_low);
      alsd_pkg::PH_HIGH:   phase_len = alsd_pkg::at_least_one(alsd_pkg::LongW'(
                             cur_bit ? timing_i.one_high : timing_i.zero_high));
      alsd_pkg::PH_LOW:    phase_len = alsd_pkg::at_least_one(alsd_pkg::LongW'(
                             cur_bit ? timing_i.one_low : timing_i.zero_low));
      alsd_pkg::PH_LATCH:  phase_len = alsd_pkg::at_least_one(timing_i.latch_low);
      alsd_pkg::PH_SETTLE: phase_len = alsd_pkg::at_least_one(
                             alsd_pkg::LongW'(timing_i.settle));
      default:             phase_len = alsd_pkg::LongW'(1);
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    led_ptr_d  = led_ptr_q;
    bit_ptr_d  = bit_ptr_q;
    tick_cnt_d = tick_cnt_q;
    done       = 1'b0;
    if (cmd_i.start) begin
      phase_d    = alsd_pkg::PH_RESET;
      led_ptr_d  = '0;
      bit_ptr_d  = '0;
      tick_cnt_d = '0;
    end else if (cmd_i.tick && (phase_q != alsd_pkg::PH_IDLE)) begin
      tick_cnt_d = tick_inc;
      // end of phase, or counter wrapped round
      if ((tick_inc >= phase_len) || (tick_inc == '0)) begin
        tick_cnt_d = '0;
        unique case (phase_q)
          alsd_pkg::PH_RESET: begin
            led_ptr_d = '0;
            bit_ptr_d = '0;
            phase_d   = (eff_count_i == '0) ? alsd_pkg::PH_LATCH : alsd_pkg::PH_HIGH;
          end
          alsd_pkg::PH_HIGH: begin
            phase_d = alsd_pkg::PH_LOW;
          end
          alsd_pkg::PH_LOW: begin
            if (bit_ptr_q < alsd_pkg::LAST_BIT) begin
              bit_ptr_d = bit_ptr_q + alsd_pkg::BitPtrW'(1);
              phase_d   = alsd_pkg::PH_HIGH;
            end else if ((CntW'(led_ptr_q) + CntW'(1)) < eff_count_i) begin
              bit_ptr_d = '0;
              led_ptr_d = led_ptr_q + PtrW'(1);
              phase_d   = alsd_pkg::PH_HIGH;
            end else begin
              phase_d = alsd_pkg::PH_LATCH;
            end
          end
          alsd_pkg::PH_LATCH: begin
            if (timing_i.settle != '0) begin
              phase_d = alsd_pkg::PH_SETTLE;
            end else begin
              phase_d = alsd_pkg::PH_IDLE;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = alsd_pkg::PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= alsd_pkg::PH_IDLE;
      led_ptr_q  <= '0;
      bit_ptr_q  <= '0;
      tick_cnt_q <= '0;
    end else begin
      phase_q    <= phase_d;
      led_ptr_q  <= led_ptr_d;
      bit_ptr_q  <= bit_ptr_d;
      tick_cnt_q <= tick_cnt_d;
    end
  end

  // fetch the colour for the pointer the next tick will use
  assign rd_addr_o = led_ptr_d;

  assign stat_o.busy_now  = (phase_q != alsd_pkg::PH_IDLE);
  assign stat_o.busy_next = (phase_d != alsd_pkg::PH_IDLE);
  assign stat_o.level     = (phase_q == alsd_pkg::PH_HIGH) ||
                            (phase_q == alsd_pkg::PH_SETTLE);
  assign stat_o.done      = done;

endmodule

@@ hdl/addressable_led_serial_driver_unit.sv @@
// ----------------------------------------------------------------------------
// addressable_led_serial_driver_unit
// One-wire addressable RGB LED chain driver, one request per clock while results are taken.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per transfer:
//   a colour write, a frame start, or one time tick of the line waveform.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result per
//   request: line level for that tick, busy, frame done and request ignored.
//   Result: registered, it appears in the cycle after its request transfer.
//   Throughput: one request per cycle; the output register and in_ready_o
//   let a new request in whenever the held result is taken in that cycle.
//   Every request is decided combinationally; the pixel store is read in the
//   cycle before the bit that needs it, through its registered read port.
//   Reset: timing registers take their defaults, the frame goes idle with the
//   line low, and per-entry valid flags make the whole pixel store read as
//   zero at once, without a clearing pass.
//   Receiver stall: the result register holds its value and in_ready_o drops
//   until the result is taken; no request or result is lost.
//   Configuration: a write enable, register index and data, taken at once;
//   write only while idle.
// ----------------------------------------------------------------------------
module addressable_led_serial_driver_unit #(
  parameter int MaxLeds = alsd_pkg::MaxLedsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [alsd_pkg::ReqTypeW-1:0]  req_type_i,
  input  logic [alsd_pkg::LedIndexW-1:0] led_index_i,
  input  logic [alsd_pkg::PixelW-1:0]    color_rgb_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           data_line_o,
  output logic                           busy_res_o,
  output logic                           frame_done_o,
  output logic                           request_ignored_o,
  // configuration port
  input  logic                           cfg_we_i,
  input  logic [alsd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [alsd_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int PtrW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam int CntW = ($clog2(MaxLeds + 1) > alsd_pkg::LedCountW) ?
                        $clog2(MaxLeds + 1) : alsd_pkg::LedCountW;

  // configuration registers
  logic [alsd_pkg::LedCountW-1:0] led_count_q;
  alsd_pkg::timing_t              timing_q;

  // result register
  logic out_valid_q;
  logic data_line_q, busy_res_q, frame_done_q, ignored_q;

  logic                        accept;
  logic [CntW-1:0]             eff_count;
  logic [CntW-1:0]             idx_ext;
  logic                        idx_bad;
  logic                        wr_en;
  logic [alsd_pkg::PixelW-1:0] grb_word;
  logic [alsd_pkg::PixelW-1:0] pix_word;
  logic [PtrW-1:0]             rd_addr;
  logic                        ignored_d;
  alsd_pkg::seq_cmd_t          seq_cmd;
  alsd_pkg::seq_stat_t         seq_stat;

  // take a request whenever the result slot is empty or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // limit the LED count to the store depth
  assign eff_count = (CntW'(led_count_q) > CntW'(MaxLeds)) ? CntW'(MaxLeds)
                                                           : CntW'(led_count_q);
  assign idx_ext   = CntW'(led_index_i);
  assign idx_bad   = (idx_ext >= eff_count) || (idx_ext >= CntW'(MaxLeds));

  // keep colours in wire order: green, red, blue
  assign grb_word = {color_rgb_i[15:8], color_rgb_i[23:16], color_rgb_i[7:0]};

  always_comb begin
    wr_en         = 1'b0;
    seq_cmd.start = 1'b0;
    seq_cmd.tick  = 1'b0;
    ignored_d     = 1'b0;
    unique case (req_type_i)
      alsd_pkg::REQ_WRITE: begin
        if (seq_stat.busy_now || idx_bad) begin
          ignored_d = 1'b1;
        end else begin
          wr_en = accept;
        end
      end
      alsd_pkg::REQ_START: begin
        if (seq_stat.busy_now) begin
          ignored_d = 1'b1;
        end else begin
          seq_cmd.start = accept;
        end
      end
      alsd_pkg::REQ_TICK: begin
        seq_cmd.tick = accept;
      end
      alsd_pkg::REQ_NONE: begin
        ignored_d = 1'b0;
      end
      default: begin
        ignored_d = 1'b0;
      end
    endcase
  end

  alsd_pixel_mem #(
    .Depth (MaxLeds),
    .AddrW (PtrW)
  ) u_pixel_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_ext[PtrW-1:0]),
    .wr_data_i (grb_word),
    .rd_addr_i (rd_addr),
    .rd_data_o (pix_word)
  );

  alsd_frame_seq #(
    .MaxLeds (MaxLeds),
    .PtrW    (PtrW),
    .CntW    (CntW)
  ) u_frame_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (seq_cmd),
    .timing_i    (timing_q),
    .eff_count_i (eff_count),
    .pix_word_i  (pix_word),
    .rd_addr_o   (rd_addr),
    .stat_o      (seq_stat)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q        <= alsd_pkg::LED_COUNT_RST;
      timing_q.zero_high <= alsd_pkg::ZERO_HIGH_RST;
      timing_q.zero_low  <= alsd_pkg::ZERO_LOW_RST;
      timing_q.one_high  <= alsd_pkg::ONE_HIGH_RST;
      timing_q.one_low   <= alsd_pkg::ONE_LOW_RST;
      timing_q.reset_low <= alsd_pkg::RESET_LOW_RST;
      timing_q.latch_low <= alsd_pkg::LATCH_LOW_RST;
      timing_q.settle    <= alsd_pkg::SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        alsd_pkg::CFG_LED_COUNT: led_count_q        <= cfg_data_i[alsd_pkg::LedCountW-1:0];
        alsd_pkg::CFG_ZERO_HIGH: timing_q.zero_high <= cfg_data_i[alsd_pkg::ShortW-1:0];
        alsd_pkg::CFG_ZERO_LOW:  timing_q.zero_low  <= cfg_data_i[alsd_pkg::ShortW-1:0];
        alsd_pkg::CFG_ONE_HIGH:  timing_q.one_high  <= cfg_data_i[alsd_pkg::ShortW-1:0];
        alsd_pkg::CFG_ONE_LOW:   timing_q.one_low   <= cfg_data_i[alsd_pkg::ShortW-1:0];
        alsd_pkg::CFG_RESET_LOW: timing_q.reset_low <= cfg_data_i;
        alsd_pkg::CFG_LATCH_LOW: timing_q.latch_low <= cfg_data_i;
        alsd_pkg::CFG_SETTLE:    timing_q.settle    <= cfg_data_i[alsd_pkg::ShortW-1:0];
        default:                 led_count_q        <= led_count_q;
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload: the line level is that of the phase in force before
  // this request, which is low whenever the frame is idle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_line_q  <= seq_stat.level;
      busy_res_q   <= seq_stat.busy_next;
      frame_done_q <= seq_stat.done;
      ignored_q    <= ignored_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_line_o       = data_line_q;
  assign busy_res_o        = busy_res_q;
  assign frame_done_o      = frame_done_q;
  assign request_ignored_o = ignored_q;

endmodule

@@ hdl/alsd_checker.sv @@
// ----------------------------------------------------------------------------
// alsd_checker
// Port-level checks for the LED serial driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "addressable_led_serial_driver_unit_assert.svh"

module alsd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [alsd_pkg::ReqTypeW-1:0]  req_type_i,
  input logic [alsd_pkg::LedIndexW-1:0] led_index_i,
  input logic [alsd_pkg::PixelW-1:0]    color_rgb_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           data_line_o,
  input logic                           busy_res_o,
  input logic                           frame_done_o,
  input logic                           request_ignored_o,
  input logic                           cfg_we_i,
  input logic [alsd_pkg::CfgIndexW-1:0] cfg_index_i,
  input logic [alsd_pkg::CfgDataW-1:0]  cfg_data_i
);

  // a finished frame leaves the driver idle
  `ALSD_ASSERT(a_done_idle, (out_valid_o && frame_done_o) |-> !busy_res_o, "done while busy")

  // an empty result slot always takes a request
  `ALSD_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "not ready with empty slot")

  // every accepted request yields a result in the next cycle
  `ALSD_ASSERT(a_result_follows, (in_valid_i && in_ready_o) |=> out_valid_o, "result missing")

  // a stalled result holds its value
  `ALSD_ASSERT(a_result_holds, (out_valid_o && !out_ready_i) |=> (out_valid_o &&
    $stable(data_line_o) && $stable(busy_res_o) && $stable(frame_done_o) &&
    $stable(request_ignored_o)), "stalled result changed")

endmodule

bind addressable_led_serial_driver_unit alsd_checker u_alsd_checker (.*);
